// ===== hdl/tppf_pkg.sv =====
// Shared types, constants and small lookup functions for the tile plane pixel fetch.
package tppf_pkg;

  // Video memory is split into an even-byte and an odd-byte bank per copy.
  localparam int unsigned VRAM_BYTES      = 65536;
  localparam int unsigned VRAM_BANK_DEPTH = VRAM_BYTES / 2;
  localparam int unsigned VRAM_BANK_AW    = $clog2(VRAM_BANK_DEPTH);

  // One copy of video memory per pipeline stage that reads it.
  localparam int unsigned VRAM_COPIES = 3;
  localparam int unsigned VC_HSCROLL  = 0;
  localparam int unsigned VC_DESC     = 1;
  localparam int unsigned VC_PATTERN  = 2;

  localparam int unsigned CRAM_BYTES      = 128;
  localparam int unsigned CRAM_BANK_DEPTH = CRAM_BYTES / 2;
  localparam int unsigned CRAM_BANK_AW    = $clog2(CRAM_BANK_DEPTH);

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Register index, paddr[4:2]
  localparam logic [2:0] REG_PLANE_A_BASE = 3'd0;
  localparam logic [2:0] REG_PLANE_B_BASE = 3'd1;
  localparam logic [2:0] REG_HSCROLL_BASE = 3'd2;
  localparam logic [2:0] REG_HSCROLL_MODE = 3'd3;
  localparam logic [2:0] REG_VSCROLL_2CEL = 3'd4;
  localparam logic [2:0] REG_WIDTH_CODE   = 3'd5;
  localparam logic [2:0] REG_HEIGHT_CODE  = 3'd6;

  // Horizontal scroll modes; the other codes are full screen.
  localparam logic [1:0] HS_MODE_BAND = 2'd2;
  localparam logic [1:0] HS_MODE_LINE = 2'd3;

  // Plane size codes
  localparam logic [1:0] SIZE_32  = 2'd0;
  localparam logic [1:0] SIZE_64  = 2'd1;

  // Nametable descriptor fields
  localparam int unsigned DESC_VFLIP_BIT = 12;
  localparam int unsigned DESC_HFLIP_BIT = 11;

  typedef enum logic [1:0] {
    KIND_RENDER = 2'd0,
    KIND_VRAM   = 2'd1,
    KIND_VSRAM  = 2'd2,
    KIND_CRAM   = 2'd3
  } kind_e;

  // Fields every word carries down the pipeline.
  typedef struct packed {
    kind_e       kind;
    logic        draw;   // render word with an on-screen column
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  // 3-bit channel scaled by 255/7
  function automatic logic [7:0] chan_scale(input logic [2:0] c);
    logic [7:0] v;
    unique case (c)
      3'd0: v = 8'd0;
      3'd1: v = 8'd36;
      3'd2: v = 8'd72;
      3'd3: v = 8'd109;
      3'd4: v = 8'd145;
      3'd5: v = 8'd182;
      3'd6: v = 8'd218;
      3'd7: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Pixel coordinate mask for a plane size code
  function automatic logic [9:0] size_mask(input logic [1:0] code);
    logic [9:0] m;
    unique case (code)
      SIZE_32: m = 10'h0FF;
      SIZE_64: m = 10'h1FF;
      default: m = 10'h3FF;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/tppf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module tppf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tile_plane_pixel_fetch.sv =====
// Tile plane pixel fetch: six-stage pipeline from scroll lookup to RGBA pixel.
// A render word on screen reaches m_axis through the stage and output registers.
// Throughput: one word per cycle if the skid register is empty; each dependent
// memory read (scroll, nametable, pattern, color) sits in its own stage on its
// own copy of the memory. Reset clears the pipeline, output and skid valid bits
// and configuration registers; memory contents stay undefined until written.
module tile_plane_pixel_fetch #(
  parameter int unsigned LINE_WIDTH    = 320,
  parameter int unsigned VSCROLL_BYTES = 80
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] mem_address, [23:16] mem_data, [24] plane, [33:25] column,
  // [41:34] line, [47:42] zero
  input  logic [47:0]                   s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]                    s_axis_tuser_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] pixel_rgba
  output logic [31:0]                   m_axis_tdata_o,
  // [0] opaque
  output logic [0:0]                    m_axis_tuser_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tppf_pkg::APB_AW-1:0]   paddr,
  input  logic [tppf_pkg::APB_DW-1:0]   pwdata,
  output logic [tppf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  // Scroll memory is split into even and odd byte banks; a vertical
  // scroll word always starts at an even byte.
  localparam int unsigned VsEvenDepth = (VSCROLL_BYTES + 1) / 2;
  localparam int unsigned VsOddDepth  = VSCROLL_BYTES / 2;
  localparam int unsigned VsEvenAw    = $clog2(VsEvenDepth);
  localparam int unsigned VsOddAw     = $clog2(VsOddDepth);
  localparam logic [16:0] VsBytes     = 17'(VSCROLL_BYTES);
  localparam logic [6:0]  VsEvenLim   = 7'(VsEvenDepth);
  localparam logic [6:0]  VsOddLim    = 7'(VsOddDepth);
  localparam logic [9:0]  LineW       = 10'(LINE_WIDTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0] plane_a_base_q, plane_b_base_q;
  logic [5:0] hs_base_q;
  logic [1:0] hs_mode_q;
  logic       vs_two_cell_q;
  logic [1:0] width_code_q, height_code_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_a_base_q <= '0;
      plane_b_base_q <= '0;
      hs_base_q      <= '0;
      hs_mode_q      <= '0;
      vs_two_cell_q  <= 1'b0;
      width_code_q   <= '0;
      height_code_q  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        tppf_pkg::REG_PLANE_A_BASE: plane_a_base_q <= pwdata[2:0];
        tppf_pkg::REG_PLANE_B_BASE: plane_b_base_q <= pwdata[2:0];
        tppf_pkg::REG_HSCROLL_BASE: hs_base_q      <= pwdata[5:0];
        tppf_pkg::REG_HSCROLL_MODE: hs_mode_q      <= pwdata[1:0];
        tppf_pkg::REG_VSCROLL_2CEL: vs_two_cell_q  <= pwdata[0];
        tppf_pkg::REG_WIDTH_CODE:   width_code_q   <= pwdata[1:0];
        tppf_pkg::REG_HEIGHT_CODE:  height_code_q  <= pwdata[1:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      tppf_pkg::REG_PLANE_A_BASE: prdata = 32'(plane_a_base_q);
      tppf_pkg::REG_PLANE_B_BASE: prdata = 32'(plane_b_base_q);
      tppf_pkg::REG_HSCROLL_BASE: prdata = 32'(hs_base_q);
      tppf_pkg::REG_HSCROLL_MODE: prdata = 32'(hs_mode_q);
      tppf_pkg::REG_VSCROLL_2CEL: prdata = 32'(vs_two_cell_q);
      tppf_pkg::REG_WIDTH_CODE:   prdata = 32'(width_code_q);
      tppf_pkg::REG_HEIGHT_CODE:  prdata = 32'(height_code_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipe moves together unless the skid
  // register is occupied. The output register lets a new word in while a
  // finished pixel still waits.
  // ---------------------------------------------------------------------------
  logic advance;
  logic skid_valid_q;

  assign advance         = ~skid_valid_q;
  assign s_axis_tready_o = advance;

  // ---------------------------------------------------------------------------
  // Memory instances and their port signals
  // ---------------------------------------------------------------------------
  logic [tppf_pkg::VRAM_COPIES-1:0]                               vr_wen;
  logic [tppf_pkg::VRAM_COPIES-1:0][15:0]                         vr_waddr;
  logic [tppf_pkg::VRAM_COPIES-1:0][7:0]                          vr_wdata;
  logic [tppf_pkg::VRAM_COPIES-1:0][tppf_pkg::VRAM_BANK_AW-1:0]   vr_raddr;
  logic [tppf_pkg::VRAM_COPIES-1:0][1:0][7:0]                     vr_rdata;

  for (genvar c = 0; c < tppf_pkg::VRAM_COPIES; c++) begin : g_vram_copy
    for (genvar b = 0; b < 2; b++) begin : g_bank
      tppf_ram #(
        .WIDTH (8),
        .DEPTH (tppf_pkg::VRAM_BANK_DEPTH)
      ) u_vram (
        .clk_i   (clk_i),
        .we_i    (vr_wen[c] && (vr_waddr[c][0] == 1'(b))),
        .waddr_i (vr_waddr[c][tppf_pkg::VRAM_BANK_AW:1]),
        .wdata_i (vr_wdata[c]),
        .re_i    (advance),
        .raddr_i (vr_raddr[c]),
        .rdata_o (vr_rdata[c][b])
      );
    end
  end

  logic                vs_wen;
  logic                vs_even_we, vs_odd_we;
  logic [VsEvenAw-1:0] vs_even_raddr;
  logic [VsOddAw-1:0]  vs_odd_raddr;
  logic [7:0]          vs_even_rdata, vs_odd_rdata;

  logic                               cram_wen;
  logic [tppf_pkg::CRAM_BANK_AW-1:0]  cram_raddr;
  logic [7:0]                         cram_even_rdata, cram_odd_rdata;

  // ---------------------------------------------------------------------------
  // Stage 1: input register; horizontal scroll and vertical scroll reads
  // ---------------------------------------------------------------------------
  tppf_pkg::item_t in_item;
  logic            s1_valid_q;
  tppf_pkg::item_t s1_item_q;
  logic            s1_plane_q;
  logic [8:0]      s1_col_q;
  logic [7:0]      s1_line_q;
  logic [7:0]      hs_line_sel;
  logic [5:0]      va_row;
  logic            s2_vs_even_ok_d, s2_vs_odd_ok_d;

  always_comb begin
    in_item.kind = tppf_pkg::kind_e'(s_axis_tuser_i);
    in_item.addr = s_axis_tdata_i[15:0];
    in_item.data = s_axis_tdata_i[23:16];
    in_item.draw = (in_item.kind == tppf_pkg::KIND_RENDER) &&
                   ({1'b0, s_axis_tdata_i[33:25]} < LineW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_item_q  <= in_item;
      s1_plane_q <= s_axis_tdata_i[24];
      s1_col_q   <= s_axis_tdata_i[33:25];
      s1_line_q  <= s_axis_tdata_i[41:34];
    end
  end

  // Scroll table entry: base + line offset * 4 + plane * 2, always even
  // and never past the top of memory, so it maps to one word row.
  always_comb begin
    unique case (hs_mode_q)
      tppf_pkg::HS_MODE_BAND: hs_line_sel = {3'd0, s1_line_q[7:3]};
      tppf_pkg::HS_MODE_LINE: hs_line_sel = s1_line_q;
      default:                hs_line_sel = 8'd0;
    endcase
  end

  assign vr_raddr[tppf_pkg::VC_HSCROLL] = {hs_base_q, hs_line_sel, s1_plane_q};
  assign vr_wen[tppf_pkg::VC_HSCROLL]   = s1_valid_q & advance &
                                          (s1_item_q.kind == tppf_pkg::KIND_VRAM);
  assign vr_waddr[tppf_pkg::VC_HSCROLL] = s1_item_q.addr;
  assign vr_wdata[tppf_pkg::VC_HSCROLL] = s1_item_q.data;

  // Vertical scroll word row: plane, plus the 16-pixel column in two-cell mode
  assign va_row          = {(vs_two_cell_q ? s1_col_q[8:4] : 5'd0), s1_plane_q};
  assign s2_vs_even_ok_d = {1'b0, va_row} < VsEvenLim;
  assign s2_vs_odd_ok_d  = {1'b0, va_row} < VsOddLim;
  assign vs_even_raddr   = s2_vs_even_ok_d ? va_row[VsEvenAw-1:0] : '0;
  assign vs_odd_raddr    = s2_vs_odd_ok_d ? va_row[VsOddAw-1:0] : '0;

  assign vs_wen     = s1_valid_q & advance & (s1_item_q.kind == tppf_pkg::KIND_VSRAM) &
                      ({1'b0, s1_item_q.addr} < VsBytes);
  assign vs_even_we = vs_wen & ~s1_item_q.addr[0];
  assign vs_odd_we  = vs_wen & s1_item_q.addr[0];

  tppf_ram #(
    .WIDTH (8),
    .DEPTH (VsEvenDepth)
  ) u_vsram_even (
    .clk_i   (clk_i),
    .we_i    (vs_even_we),
    .waddr_i (s1_item_q.addr[VsEvenAw:1]),
    .wdata_i (s1_item_q.data),
    .re_i    (advance),
    .raddr_i (vs_even_raddr),
    .rdata_o (vs_even_rdata)
  );

  tppf_ram #(
    .WIDTH (8),
    .DEPTH (VsOddDepth)
  ) u_vsram_odd (
    .clk_i   (clk_i),
    .we_i    (vs_odd_we),
    .waddr_i (s1_item_q.addr[VsOddAw:1]),
    .wdata_i (s1_item_q.data),
    .re_i    (advance),
    .raddr_i (vs_odd_raddr),
    .rdata_o (vs_odd_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: scrolled coordinates, wrapped to the plane size
  // ---------------------------------------------------------------------------
  logic            s2_valid_q;
  tppf_pkg::item_t s2_item_q;
  logic            s2_plane_q;
  logic [8:0]      s2_col_q;
  logic [7:0]      s2_line_q;
  logic            s2_vs_even_ok_q, s2_vs_odd_ok_q;
  logic [15:0]     hs_word, vs_word, x_diff, y_sum;
  logic [9:0]      s3_x_d, s3_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_item_q       <= s1_item_q;
      s2_plane_q      <= s1_plane_q;
      s2_col_q        <= s1_col_q;
      s2_line_q       <= s1_line_q;
      s2_vs_even_ok_q <= s2_vs_even_ok_d;
      s2_vs_odd_ok_q  <= s2_vs_odd_ok_d;
    end
  end

  // even byte is the high half of a word
  assign hs_word = {vr_rdata[tppf_pkg::VC_HSCROLL][0], vr_rdata[tppf_pkg::VC_HSCROLL][1]};
  assign vs_word = {(s2_vs_even_ok_q ? vs_even_rdata : 8'd0),
                    (s2_vs_odd_ok_q ? vs_odd_rdata : 8'd0)};
  assign x_diff  = {7'd0, s2_col_q} - hs_word;
  assign y_sum   = {8'd0, s2_line_q} + vs_word;
  assign s3_x_d  = x_diff[9:0] & tppf_pkg::size_mask(width_code_q);
  assign s3_y_d  = y_sum[9:0] & tppf_pkg::size_mask(height_code_q);

  // ---------------------------------------------------------------------------
  // Stage 3: nametable descriptor read
  // ---------------------------------------------------------------------------
  logic            s3_valid_q;
  tppf_pkg::item_t s3_item_q;
  logic            s3_plane_q;
  logic [9:0]      s3_x_q, s3_y_q;
  logic [2:0]      nt_base;
  logic [13:0]     nt_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_item_q  <= s2_item_q;
      s3_plane_q <= s2_plane_q;
      s3_x_q     <= s3_x_d;
      s3_y_q     <= s3_y_d;
    end
  end

  // cell = tile row * width + tile column; tile column is below the width
  always_comb begin
    unique case (width_code_q)
      tppf_pkg::SIZE_32: nt_cell = {2'd0, s3_y_q[9:3], s3_x_q[7:3]};
      tppf_pkg::SIZE_64: nt_cell = {1'd0, s3_y_q[9:3], s3_x_q[8:3]};
      default:           nt_cell = {s3_y_q[9:3], s3_x_q[9:3]};
    endcase
  end

  assign nt_base = s3_plane_q ? plane_b_base_q : plane_a_base_q;
  // word row = base * 4096 + cell, wrapping with the 16-bit byte address
  assign vr_raddr[tppf_pkg::VC_DESC] = {nt_base, 12'd0} + {1'b0, nt_cell};
  assign vr_wen[tppf_pkg::VC_DESC]   = s3_valid_q & advance &
                                       (s3_item_q.kind == tppf_pkg::KIND_VRAM);
  assign vr_waddr[tppf_pkg::VC_DESC] = s3_item_q.addr;
  assign vr_wdata[tppf_pkg::VC_DESC] = s3_item_q.data;

  // ---------------------------------------------------------------------------
  // Stage 4: flips and pattern byte read
  // ---------------------------------------------------------------------------
  logic            s4_valid_q;
  tppf_pkg::item_t s4_item_q;
  logic [2:0]      s4_trow_q, s4_tcol_q;
  logic [15:0]     desc;
  logic [2:0]      trow_f, tcol_f;
  logic            s5_sel_d, s5_nib_d;
  logic [1:0]      s5_pal_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_item_q <= s3_item_q;
      s4_trow_q <= s3_y_q[2:0];
      s4_tcol_q <= s3_x_q[2:0];
    end
  end

  assign desc   = {vr_rdata[tppf_pkg::VC_DESC][0], vr_rdata[tppf_pkg::VC_DESC][1]};
  assign trow_f = desc[tppf_pkg::DESC_VFLIP_BIT] ? ~s4_trow_q : s4_trow_q;
  assign tcol_f = desc[tppf_pkg::DESC_HFLIP_BIT] ? ~s4_tcol_q : s4_tcol_q;

  // byte = tile * 32 + row * 4 + col / 2; both banks read at its word row
  assign vr_raddr[tppf_pkg::VC_PATTERN] = {desc[10:0], trow_f, tcol_f[2]};
  assign vr_wen[tppf_pkg::VC_PATTERN]   = s4_valid_q & advance &
                                          (s4_item_q.kind == tppf_pkg::KIND_VRAM);
  assign vr_waddr[tppf_pkg::VC_PATTERN] = s4_item_q.addr;
  assign vr_wdata[tppf_pkg::VC_PATTERN] = s4_item_q.data;

  assign s5_sel_d = tcol_f[1];
  assign s5_nib_d = tcol_f[0];
  assign s5_pal_d = desc[14:13];

  // ---------------------------------------------------------------------------
  // Stage 5: pixel index and color memory read
  // ---------------------------------------------------------------------------
  logic            s5_valid_q;
  tppf_pkg::item_t s5_item_q;
  logic            s5_sel_q, s5_nib_q;
  logic [1:0]      s5_pal_q;
  logic [7:0]      pat_pair;
  logic [3:0]      pix_idx;
  logic            s6_opaque_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (advance) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s5_item_q <= s4_item_q;
      s5_sel_q  <= s5_sel_d;
      s5_nib_q  <= s5_nib_d;
      s5_pal_q  <= s5_pal_d;
    end
  end

  assign pat_pair = s5_sel_q ? vr_rdata[tppf_pkg::VC_PATTERN][1]
                             : vr_rdata[tppf_pkg::VC_PATTERN][0];
  // left pixel in the high nibble
  assign pix_idx     = s5_nib_q ? pat_pair[3:0] : pat_pair[7:4];
  assign s6_opaque_d = pix_idx != 4'd0;
  assign cram_raddr  = {s5_pal_q, pix_idx};

  assign cram_wen = s5_valid_q & advance & (s5_item_q.kind == tppf_pkg::KIND_CRAM) &
                    (s5_item_q.addr[15:7] == 9'd0);

  tppf_ram #(
    .WIDTH (8),
    .DEPTH (tppf_pkg::CRAM_BANK_DEPTH)
  ) u_cram_even (
    .clk_i   (clk_i),
    .we_i    (cram_wen & ~s5_item_q.addr[0]),
    .waddr_i (s5_item_q.addr[tppf_pkg::CRAM_BANK_AW:1]),
    .wdata_i (s5_item_q.data),
    .re_i    (advance),
    .raddr_i (cram_raddr),
    .rdata_o (cram_even_rdata)
  );

  tppf_ram #(
    .WIDTH (8),
    .DEPTH (tppf_pkg::CRAM_BANK_DEPTH)
  ) u_cram_odd (
    .clk_i   (clk_i),
    .we_i    (cram_wen & s5_item_q.addr[0]),
    .waddr_i (s5_item_q.addr[tppf_pkg::CRAM_BANK_AW:1]),
    .wdata_i (s5_item_q.data),
    .re_i    (advance),
    .raddr_i (cram_raddr),
    .rdata_o (cram_odd_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: color expansion
  // ---------------------------------------------------------------------------
  logic            s6_valid_q;
  tppf_pkg::item_t s6_item_q;
  logic            s6_opaque_q;
  logic            res_valid;
  logic [31:0]     res_rgba;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (advance) begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s6_item_q   <= s5_item_q;
      s6_opaque_q <= s6_opaque_d;
    end
  end

  // even byte: blue in bits 3:1; odd byte: green 7:5, red 3:1
  assign res_rgba  = s6_opaque_q ?
                     {tppf_pkg::chan_scale(cram_odd_rdata[3:1]),
                      tppf_pkg::chan_scale(cram_odd_rdata[7:5]),
                      tppf_pkg::chan_scale(cram_even_rdata[3:1]),
                      8'hFF} : 32'd0;
  assign res_valid = advance & s6_valid_q & s6_item_q.draw;

  // ---------------------------------------------------------------------------
  // Output register with skid
  // ---------------------------------------------------------------------------
  logic        out_valid_q;
  logic [31:0] out_rgba_q, skid_rgba_q;
  logic        out_opaque_q, skid_opaque_q;
  logic        out_fire, out_from_skid, out_from_pipe, skid_load;

  assign out_fire      = out_valid_q & m_axis_tready_i;
  assign out_from_skid = skid_valid_q & out_fire;
  assign out_from_pipe = ~skid_valid_q & (~out_valid_q | out_fire);
  assign skid_load     = ~skid_valid_q & out_valid_q & ~m_axis_tready_i & res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_from_skid) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else if (out_from_pipe) begin
        out_valid_q <= res_valid;
      end else if (skid_load) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_rgba_q   <= skid_rgba_q;
      out_opaque_q <= skid_opaque_q;
    end else if (out_from_pipe) begin
      out_rgba_q   <= res_rgba;
      out_opaque_q <= s6_opaque_q;
    end
    if (skid_load) begin
      skid_rgba_q   <= res_rgba;
      skid_opaque_q <= s6_opaque_q;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_rgba_q;
  assign m_axis_tuser_o[0] = out_opaque_q;

endmodule
